[rtl/core/polygon_scanline_span_fill_top_defines.svh]
// ----------------------------------------------------------------------------
// polygon scanline span fill assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef POLYGON_SCANLINE_SPAN_FILL_TOP_DEFINES_SVH
`define POLYGON_SCANLINE_SPAN_FILL_TOP_DEFINES_SVH
`ifndef SYNTH
`define PSF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("psf assertion failed");
`define PSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psf assertion failed");
`else
`define PSF_ASSERT(lbl, prop)
`define PSF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/core/psf_pkg.sv]
// ----------------------------------------------------------------------------
// psf_pkg
// constants, types and span end rounding for the polygon span fill
// ----------------------------------------------------------------------------
`default_nettype none
package psf_pkg;

  localparam int COORD_BITS    = 12;
  localparam int FRAC_BITS     = 16;
  localparam int MAX_VERTS_DEF = 64;
  localparam int RESULT_CAP    = 32;
  localparam int POS_W         = COORD_BITS + FRAC_BITS + 2;
  localparam int DX_W          = COORD_BITS + 1;
  localparam int MA_W          = COORD_BITS + 3;
  localparam int MUL_W         = MA_W + DX_W;
  localparam int DV_W          = 2 * COORD_BITS + FRAC_BITS + 2;
  localparam int DVS_W         = COORD_BITS + 2;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_ROW   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic signed [POS_W-1:0]  pos;
    logic signed [POS_W-1:0]  step;
    logic [COORD_BITS-1:0]    rows;
  } act_entry_t;

  typedef enum logic [2:0] {
    PH_LOADING = 3'b001,
    PH_FILLING = 3'b010,
    PH_DONE    = 3'b100
  } phase_t;

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_ADV_RD   = 16'h0002,
    S_ADV_WR   = 16'h0004,
    S_ENT_RD   = 16'h0008,
    S_ENT_CHK  = 16'h0010,
    S_DIV_STEP = 16'h0020,
    S_DIV_POS  = 16'h0040,
    S_SRT_INIT = 16'h0080,
    S_SRT_LD   = 16'h0100,
    S_SRT_CMP  = 16'h0200,
    S_SRT_END  = 16'h0400,
    S_EMIT_INIT = 16'h0800,
    S_EMIT_RDA = 16'h1000,
    S_EMIT_RDB = 16'h2000,
    S_EMIT_OUT = 16'h4000
  } state_t;

  // ceil(pos + step/2) saturated to the coordinate range
  function automatic logic [COORD_BITS-1:0] span_end(
    input logic signed [POS_W-1:0] pos,
    input logic signed [POS_W-1:0] step
  );
    logic signed [POS_W+1:0] v;
    logic signed [POS_W+1:0] c;
    logic signed [POS_W+1:0] rnd;
    logic signed [POS_W+1:0] cmax;
    rnd  = $signed((POS_W+2)'((64'd1 << (FRAC_BITS + 1)) - 64'd1));
    cmax = $signed((POS_W+2)'((64'd1 << COORD_BITS) - 64'd1));
    v = $signed({pos[POS_W-1], pos, 1'b0}) + $signed({{2{step[POS_W-1]}}, step});
    c = (v + rnd) >>> (FRAC_BITS + 1);
    if (c < 0) begin
      span_end = '0;
    end else if (c > cmax) begin
      span_end = '1;
    end else begin
      span_end = c[COORD_BITS-1:0];
    end
  endfunction

endpackage
`default_nettype wire

[rtl/core/polygon_scanline_span_fill_top.sv]
// ----------------------------------------------------------------------------
// polygon_scanline_span_fill_top
// active edge table scanline filler: vertex store, shared divider, bubble sort
// ----------------------------------------------------------------------------
// channel   dir  handshake            payload
// in        in   in_valid/in_stall    in_kind, in_vertex_x, in_vertex_y
// out       out  out_valid/out_stall  out_span_row/left/right/valid, last, done, ovf
//
// load, clear and ack beats go from accept straight into the result register
// a row advances the A active edges, scans the S segments for new edges,
// divides for each entered edge, bubble sorts in passes and emits its spans
// the radix-2 divider (42 steps) and the single read port of the active memory
// dominate a row's work; no input is taken until the row is fully emitted
// synchronous active-low reset clears control state only, no clearing pass
// an output stall holds the result register and the span emitter
// ----------------------------------------------------------------------------
`default_nettype none
`include "polygon_scanline_span_fill_top_defines.svh"
module polygon_scanline_span_fill_top #(
  parameter int MAX_VERTS = psf_pkg::MAX_VERTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [11:0] in_vertex_x,
  input  wire logic [11:0] in_vertex_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      out_span_row,
  output logic [11:0]      out_span_left,
  output logic [11:0]      out_span_right,
  output logic             out_span_valid,
  output logic             out_last,
  output logic             out_done_res,
  output logic             out_overflow
);

  localparam int IDX_W   = $clog2(MAX_VERTS);
  localparam int CNT_W   = IDX_W + 1;
  localparam int CW      = psf_pkg::COORD_BITS;
  localparam int FB      = psf_pkg::FRAC_BITS;
  localparam int PW      = psf_pkg::POS_W;
  localparam int DXW     = psf_pkg::DX_W;
  localparam int MAW     = psf_pkg::MA_W;
  localparam int MW      = psf_pkg::MUL_W;
  localparam int DVW     = psf_pkg::DV_W;
  localparam int DSW     = psf_pkg::DVS_W;
  localparam int DCW     = $clog2(DVW + 1);
  localparam int CAP_EFF = (psf_pkg::RESULT_CAP < MAX_VERTS / 2) ?
                           psf_pkg::RESULT_CAP : MAX_VERTS / 2;

  psf_pkg::state_t     state_r;
  psf_pkg::phase_t     phase_r;
  logic [CNT_W-1:0]    vc_r;
  logic [CW-1:0]       ylow_r;
  logic [CW-1:0]       yhigh_r;
  logic [MAX_VERTS-1:0] entered_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [CW:0]         row_r;
  logic [CNT_W-1:0]    k_r;
  logic [CNT_W-1:0]    w_r;
  logic [CNT_W-1:0]    j_r;
  logic                swapped_r;
  psf_pkg::act_entry_t held_r;
  logic signed [MW-1:0] mul_r;
  logic signed [DXW-1:0] dy_r;
  logic signed [PW-1:0] step_r;
  logic [CNT_W-1:0]    nsp_r;
  logic [CNT_W-1:0]    pair_r;
  logic                edone_r;
  logic [CW-1:0]       erow_r;
  logic [CW-1:0]       left_r;

  logic [DSW-1:0]      div_rem_r;
  logic [DVW-1:0]      div_quo_r;
  logic [DSW-1:0]      div_dvs_r;
  logic [DCW-1:0]      div_cnt_r;
  logic                div_neg_r;

  logic                out_valid_r;

  // vertex memories, two registered read ports
  logic [CW-1:0] vx_mem [MAX_VERTS];
  logic [CW-1:0] vy_mem [MAX_VERTS];
  logic [CW-1:0] vx_a_r, vy_a_r, vx_b_r, vy_b_r;
  logic          vtx_we;
  logic [CNT_W-1:0] jn_c;

  assign jn_c = j_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (vtx_we) begin
      vx_mem[vc_r[IDX_W-1:0]] <= in_vertex_x;
      vy_mem[vc_r[IDX_W-1:0]] <= in_vertex_y;
    end
    vx_a_r <= vx_mem[j_r[IDX_W-1:0]];
    vy_a_r <= vy_mem[j_r[IDX_W-1:0]];
    vx_b_r <= vx_mem[jn_c[IDX_W-1:0]];
    vy_b_r <= vy_mem[jn_c[IDX_W-1:0]];
  end

  // active edge memory
  psf_pkg::act_entry_t act_mem [MAX_VERTS];
  psf_pkg::act_entry_t act_q_r;
  psf_pkg::act_entry_t act_wd;
  logic [IDX_W-1:0]    act_ra;
  logic [IDX_W-1:0]    act_wa;
  logic                act_we;

  always_ff @(posedge clk) begin
    if (act_we) begin
      act_mem[act_wa] <= act_wd;
    end
    act_q_r <= act_mem[act_ra];
  end

  logic                 in_acc;
  logic                 slot_free;
  logic                 cmp_swap;
  logic                 cmp_last;
  logic signed [PW-1:0] adv_pos;
  logic [CW-1:0]        adv_rl;
  logic signed [DXW-1:0] dx_c;
  logic signed [DXW-1:0] dy_c;
  logic signed [MAW-1:0] ma_c;
  logic signed [DVW-1:0] n_step;
  logic signed [DVW-1:0] n_pos;
  logic signed [DVW-1:0] dn_sel;
  logic signed [DXW-1:0] dd_sel;
  logic [DVW-1:0]       dn_abs;
  logic [DXW-1:0]       dd_abs;
  logic [DSW:0]         div_sh;
  logic                 div_ge;
  logic [DVW-1:0]       div_q_s;
  logic signed [PW-1:0] div_res;
  logic [CW-1:0]        span_c;
  logic [CNT_W-1:0]     half_c;
  logic [CNT_W-1:0]     nsp_c;
  logic                 row_done_c;
  logic                 seg_skip;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == psf_pkg::S_IDLE) && slot_free);
  assign in_acc    = in_valid && !in_stall;
  assign vtx_we    = in_acc && (in_kind == psf_pkg::KIND_LOAD) &&
                     (phase_r == psf_pkg::PH_LOADING) && (vc_r < CNT_W'(MAX_VERTS));

  assign adv_pos = act_q_r.pos + act_q_r.step;
  assign adv_rl  = act_q_r.rows - CW'(1);
  assign cmp_swap = held_r.pos > act_q_r.pos;
  assign cmp_last = (k_r + CNT_W'(1)) == cnt_r;

  assign dx_c = $signed({1'b0, vx_a_r}) - $signed({1'b0, vx_b_r});
  assign dy_c = $signed({1'b0, vy_a_r}) - $signed({1'b0, vy_b_r});
  assign ma_c = $signed({1'b0, row_r, 1'b1}) - $signed({2'b00, vy_a_r, 1'b0});
  assign seg_skip = entered_r[j_r[IDX_W-1:0]] || (vy_a_r == vy_b_r) ||
                    (({1'b0, vy_a_r} <= row_r) && ({1'b0, vy_b_r} <= row_r));

  assign n_step = -($signed({{(DVW-DXW){dx_c[DXW-1]}}, dx_c}) <<< FB);
  assign n_pos  = $signed({{(DVW-MW){mul_r[MW-1]}}, mul_r}) <<< (FB - 1);
  assign dn_sel = (state_r == psf_pkg::S_ENT_CHK) ? n_step : n_pos;
  assign dd_sel = (state_r == psf_pkg::S_ENT_CHK) ? dy_c : dy_r;
  assign dn_abs = dn_sel[DVW-1] ? DVW'(-dn_sel) : DVW'(dn_sel);
  assign dd_abs = dd_sel[DXW-1] ? DXW'(-dd_sel) : DXW'(dd_sel);

  assign div_sh  = {div_rem_r, div_quo_r[DVW-1]};
  assign div_ge  = div_sh >= {1'b0, div_dvs_r};
  assign div_q_s = div_neg_r ? (~div_quo_r + DVW'(1)) : div_quo_r;
  assign div_res = $signed(div_q_s[PW-1:0]);

  assign span_c     = psf_pkg::span_end(act_q_r.pos, act_q_r.step);
  assign half_c     = cnt_r >> 1;
  assign nsp_c      = (half_c > CNT_W'(CAP_EFF)) ? CNT_W'(CAP_EFF) : half_c;
  assign row_done_c = row_r == {1'b0, ylow_r};

  // active memory address and write selection
  always_comb begin
    act_ra = k_r[IDX_W-1:0];
    act_wa = w_r[IDX_W-1:0];
    act_we = 1'b0;
    act_wd = held_r;
    unique case (state_r)
      psf_pkg::S_ADV_WR: begin
        act_we = adv_rl != '0;
        act_wd = '{pos: adv_pos, step: act_q_r.step, rows: adv_rl};
      end
      psf_pkg::S_DIV_POS: begin
        act_we = div_cnt_r == '0;
        act_wa = cnt_r[IDX_W-1:0];
        act_wd = '{pos: $signed({2'b00, vx_a_r, {FB{1'b0}}}) + div_res,
                   step: step_r,
                   rows: dy_r[DXW-1] ? CW'(-dy_r) : CW'(dy_r)};
      end
      psf_pkg::S_SRT_INIT: begin
        act_ra = '0;
      end
      psf_pkg::S_SRT_CMP: begin
        act_ra = k_r[IDX_W-1:0] + IDX_W'(1);
        act_we = 1'b1;
        act_wa = k_r[IDX_W-1:0] - IDX_W'(1);
        act_wd = cmp_swap ? act_q_r : held_r;
      end
      psf_pkg::S_SRT_END: begin
        act_we = 1'b1;
        act_wa = cnt_r[IDX_W-1:0] - IDX_W'(1);
      end
      psf_pkg::S_EMIT_RDA: begin
        act_ra = {pair_r[IDX_W-2:0], 1'b0};
      end
      psf_pkg::S_EMIT_RDB, psf_pkg::S_EMIT_OUT: begin
        act_ra = {pair_r[IDX_W-2:0], 1'b1};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psf_pkg::S_IDLE;
      phase_r     <= psf_pkg::PH_LOADING;
      vc_r        <= '0;
      ylow_r      <= '1;
      yhigh_r     <= '0;
      entered_r   <= '0;
      cnt_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (div_cnt_r != '0) begin
        div_cnt_r <= div_cnt_r - DCW'(1);
        div_rem_r <= div_ge ? DSW'(div_sh - {1'b0, div_dvs_r}) : div_sh[DSW-1:0];
        div_quo_r <= {div_quo_r[DVW-2:0], div_ge};
      end
      unique case (state_r)
        psf_pkg::S_IDLE: begin
          if (in_acc) begin
            out_valid_r    <= 1'b1;
            out_span_row   <= '0;
            out_span_left  <= '0;
            out_span_right <= '0;
            out_span_valid <= 1'b0;
            out_last       <= 1'b1;
            out_done_res   <= 1'b0;
            out_overflow   <= 1'b0;
            unique case (in_kind)
              psf_pkg::KIND_LOAD: begin
                if (phase_r == psf_pkg::PH_LOADING) begin
                  if (vc_r >= CNT_W'(MAX_VERTS)) begin
                    out_overflow <= 1'b1;
                  end else begin
                    vc_r <= vc_r + CNT_W'(1);
                    if (in_vertex_y < ylow_r) ylow_r <= in_vertex_y;
                    if (in_vertex_y > yhigh_r) yhigh_r <= in_vertex_y;
                  end
                end
              end
              psf_pkg::KIND_ROW: begin
                if (phase_r == psf_pkg::PH_DONE) begin
                  out_done_res <= 1'b1;
                end else if (phase_r == psf_pkg::PH_LOADING &&
                             (vc_r < CNT_W'(3) || yhigh_r <= ylow_r)) begin
                  phase_r      <= psf_pkg::PH_DONE;
                  out_done_res <= 1'b1;
                end else begin
                  out_valid_r <= 1'b0;
                  k_r         <= '0;
                  w_r         <= '0;
                  state_r     <= psf_pkg::S_ADV_RD;
                  if (phase_r == psf_pkg::PH_LOADING) begin
                    entered_r <= '0;
                    cnt_r     <= '0;
                    row_r     <= {1'b0, yhigh_r} - (CW+1)'(1);
                    phase_r   <= psf_pkg::PH_FILLING;
                  end
                end
              end
              psf_pkg::KIND_CLEAR: begin
                vc_r      <= '0;
                ylow_r    <= '1;
                yhigh_r   <= '0;
                entered_r <= '0;
                cnt_r     <= '0;
                row_r     <= '0;
                phase_r   <= psf_pkg::PH_LOADING;
              end
              default: begin
              end
            endcase
          end
        end
        psf_pkg::S_ADV_RD: begin
          if (k_r == cnt_r) begin
            cnt_r   <= w_r;
            j_r     <= '0;
            state_r <= psf_pkg::S_ENT_RD;
          end else begin
            state_r <= psf_pkg::S_ADV_WR;
          end
        end
        psf_pkg::S_ADV_WR: begin
          if (adv_rl != '0) w_r <= w_r + CNT_W'(1);
          k_r     <= k_r + CNT_W'(1);
          state_r <= psf_pkg::S_ADV_RD;
        end
        psf_pkg::S_ENT_RD: begin
          state_r <= (jn_c >= vc_r) ? psf_pkg::S_SRT_INIT : psf_pkg::S_ENT_CHK;
        end
        psf_pkg::S_ENT_CHK: begin
          if (seg_skip) begin
            j_r     <= jn_c;
            state_r <= psf_pkg::S_ENT_RD;
          end else begin
            entered_r[j_r[IDX_W-1:0]] <= 1'b1;
            if (cnt_r >= CNT_W'(MAX_VERTS)) begin
              j_r     <= jn_c;
              state_r <= psf_pkg::S_ENT_RD;
            end else begin
              dy_r      <= dy_c;
              mul_r     <= ma_c * dx_c;
              div_rem_r <= '0;
              div_quo_r <= (dn_abs << 1) + DVW'(dd_abs);
              div_dvs_r <= DSW'({dd_abs, 1'b0});
              div_neg_r <= dn_sel[DVW-1] != dd_sel[DXW-1];
              div_cnt_r <= DCW'(DVW);
              state_r   <= psf_pkg::S_DIV_STEP;
            end
          end
        end
        psf_pkg::S_DIV_STEP: begin
          if (div_cnt_r == '0) begin
            step_r    <= div_res;
            div_rem_r <= '0;
            div_quo_r <= (dn_abs << 1) + DVW'(dd_abs);
            div_dvs_r <= DSW'({dd_abs, 1'b0});
            div_neg_r <= dn_sel[DVW-1] != dd_sel[DXW-1];
            div_cnt_r <= DCW'(DVW);
            state_r   <= psf_pkg::S_DIV_POS;
          end
        end
        psf_pkg::S_DIV_POS: begin
          if (div_cnt_r == '0) begin
            cnt_r   <= cnt_r + CNT_W'(1);
            j_r     <= jn_c;
            state_r <= psf_pkg::S_ENT_RD;
          end
        end
        psf_pkg::S_SRT_INIT: begin
          if (cnt_r < CNT_W'(2)) begin
            state_r <= psf_pkg::S_EMIT_INIT;
          end else begin
            swapped_r <= 1'b0;
            k_r       <= CNT_W'(1);
            state_r   <= psf_pkg::S_SRT_LD;
          end
        end
        psf_pkg::S_SRT_LD: begin
          held_r  <= act_q_r;
          state_r <= psf_pkg::S_SRT_CMP;
        end
        psf_pkg::S_SRT_CMP: begin
          if (cmp_swap) begin
            swapped_r <= 1'b1;
          end else begin
            held_r <= act_q_r;
          end
          if (cmp_last) begin
            state_r <= psf_pkg::S_SRT_END;
          end else begin
            k_r <= k_r + CNT_W'(1);
          end
        end
        psf_pkg::S_SRT_END: begin
          state_r <= swapped_r ? psf_pkg::S_SRT_INIT : psf_pkg::S_EMIT_INIT;
        end
        psf_pkg::S_EMIT_INIT: begin
          if (slot_free) begin
            nsp_r   <= nsp_c;
            pair_r  <= '0;
            edone_r <= row_done_c;
            erow_r  <= row_r[CW-1:0];
            if (row_done_c) begin
              phase_r <= psf_pkg::PH_DONE;
            end else begin
              row_r <= row_r - (CW+1)'(1);
            end
            if (nsp_c == '0) begin
              out_valid_r    <= 1'b1;
              out_span_row   <= row_r[CW-1:0];
              out_span_left  <= '0;
              out_span_right <= '0;
              out_span_valid <= 1'b0;
              out_last       <= 1'b1;
              out_done_res   <= row_done_c;
              out_overflow   <= 1'b0;
              state_r        <= psf_pkg::S_IDLE;
            end else begin
              state_r <= psf_pkg::S_EMIT_RDA;
            end
          end
        end
        psf_pkg::S_EMIT_RDA: begin
          state_r <= psf_pkg::S_EMIT_RDB;
        end
        psf_pkg::S_EMIT_RDB: begin
          left_r  <= span_c;
          state_r <= psf_pkg::S_EMIT_OUT;
        end
        psf_pkg::S_EMIT_OUT: begin
          if (slot_free) begin
            out_valid_r    <= 1'b1;
            out_span_row   <= erow_r;
            out_span_left  <= left_r;
            out_span_right <= span_c;
            out_span_valid <= 1'b1;
            out_last       <= (pair_r + CNT_W'(1)) == nsp_r;
            out_done_res   <= edone_r;
            out_overflow   <= 1'b0;
            pair_r         <= pair_r + CNT_W'(1);
            state_r <= ((pair_r + CNT_W'(1)) == nsp_r) ? psf_pkg::S_IDLE :
                       psf_pkg::S_EMIT_RDA;
          end
        end
        default: begin
          state_r <= psf_pkg::S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

  `PSF_ASSERT(a_vc_range, vc_r <= CNT_W'(MAX_VERTS))
  `PSF_ASSERT(a_cnt_range, cnt_r <= CNT_W'(MAX_VERTS))
  `PSF_ASSERT_NEXT(a_in_takes, in_acc, out_valid_r || (state_r != psf_pkg::S_IDLE))
  `PSF_ASSERT(a_pair_bound, (state_r == psf_pkg::S_EMIT_OUT) |-> (pair_r < nsp_r))
  `PSF_ASSERT(a_div_idle, (state_r == psf_pkg::S_IDLE) |-> (div_cnt_r == '0))

endmodule
`default_nettype wire

[verif/polygon_scanline_span_fill_top_tb.sv]
// ----------------------------------------------------------------------------
// polygon_scanline_span_fill_top_tb
// drives vertex loads, row requests and clears through the valid/stall input
// channel, predicts every output beat with an in-bench active edge table
// model and checks the result channel field by field under random idling
// ----------------------------------------------------------------------------
`default_nettype none
module polygon_scanline_span_fill_top_tb;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int VERTS = 64;
  localparam int SPAN_CAP = 32;
  localparam int RAND_ITEMS = 470;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam int TAIL_CYCLES = 1500;

  typedef struct packed {
    logic [11:0] row;
    logic [11:0] left;
    logic [11:0] right;
    logic        span_valid;
    logic        last;
    logic        done;
    logic        overflow;
  } span_beat_t;

  typedef struct {
    logic [1:0]  kind;
    logic [11:0] vx;
    logic [11:0] vy;
    bit          typed;
    span_beat_t  want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = '0;
  logic [11:0] in_vertex_x = '0;
  logic [11:0] in_vertex_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] out_span_row, out_span_left, out_span_right;
  logic        out_span_valid, out_last, out_done_res, out_overflow;

  polygon_scanline_span_fill_top dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_vertex_x, .in_vertex_y,
    .out_valid, .out_stall, .out_span_row, .out_span_left, .out_span_right,
    .out_span_valid, .out_last, .out_done_res, .out_overflow
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // fill model state
  logic [11:0] vx_mem [VERTS];
  logic [11:0] vy_mem [VERTS];
  int unsigned vert_n;
  logic [11:0] y_lo, y_hi;
  bit          seg_in [VERTS];
  longint      edge_pos [VERTS];
  longint      edge_step [VERTS];
  int unsigned edge_rows [VERTS];
  int unsigned edge_n;
  logic [12:0] row_now;
  psf_pkg::phase_t phase;

  span_beat_t  spans_pending[$];
  int          errors = 0;
  int          idle_mode = 0;
  int          items_sent = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  longint      cycles = 0;

  function automatic void clear_fill();
    foreach (seg_in[i]) seg_in[i] = 1'b0;
    vert_n = 0;
    y_lo = '1;
    y_hi = '0;
    edge_n = 0;
    row_now = '0;
    phase = psf_pkg::PH_LOADING;
  endfunction

  function automatic longint div_nearest(longint num, longint den);
    longint an, ad, q;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = (2 * an + ad) / (2 * ad);
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic logic [11:0] edge_end(longint pos, longint step);
    longint v, c;
    v = 2 * pos + step;
    if (v >= 0)
      c = (v + ((longint'(1) << (psf_pkg::FRAC_BITS + 1)) - 1)) >>>
          (psf_pkg::FRAC_BITS + 1);
    else c = -((-v) >>> (psf_pkg::FRAC_BITS + 1));
    if (c < 0) return '0;
    if (c > 4095) return '1;
    return c[11:0];
  endfunction

  function automatic span_beat_t beat(logic [11:0] row, logic [11:0] l, logic [11:0] r,
                                     logic sv, logic lst, logic dn, logic ov);
    span_beat_t b;
    b.row = row; b.left = l; b.right = r;
    b.span_valid = sv; b.last = lst; b.done = dn; b.overflow = ov;
    return b;
  endfunction

  function automatic void next_row(ref span_beat_t res[$]);
    int unsigned w, nsp;
    longint r, y1, y2, x1, x2, dx, dy, tp, ts;
    int unsigned tr;
    bit sorted, dn;
    r = row_now;
    w = 0;
    for (int k = 0; k < edge_n; k++) begin
      if (edge_rows[k] - 1 != 0) begin
        edge_pos[w] = edge_pos[k] + edge_step[k];
        edge_step[w] = edge_step[k];
        edge_rows[w] = edge_rows[k] - 1;
        w++;
      end
    end
    edge_n = w;
    for (int j = 0; j + 1 < vert_n; j++) begin
      if (seg_in[j]) continue;
      y1 = vy_mem[j];
      y2 = vy_mem[j + 1];
      if (y1 == y2 || (y1 <= r && y2 <= r)) continue;
      seg_in[j] = 1'b1;
      if (edge_n >= VERTS) continue;
      x1 = vx_mem[j];
      x2 = vx_mem[j + 1];
      dx = x1 - x2;
      dy = y1 - y2;
      edge_step[edge_n] = div_nearest(-dx * (longint'(1) << psf_pkg::FRAC_BITS), dy);
      edge_pos[edge_n] = x1 * (longint'(1) << psf_pkg::FRAC_BITS) +
          div_nearest((2 * r + 1 - 2 * y1) * dx *
                      (longint'(1) << (psf_pkg::FRAC_BITS - 1)), dy);
      edge_rows[edge_n] = (dy < 0) ? -dy : dy;
      edge_n++;
    end
    do begin
      sorted = 1'b1;
      for (int k = 0; k + 1 < edge_n; k++) begin
        if (edge_pos[k] > edge_pos[k + 1]) begin
          tp = edge_pos[k]; ts = edge_step[k]; tr = edge_rows[k];
          edge_pos[k] = edge_pos[k + 1];
          edge_step[k] = edge_step[k + 1];
          edge_rows[k] = edge_rows[k + 1];
          edge_pos[k + 1] = tp; edge_step[k + 1] = ts; edge_rows[k + 1] = tr;
          sorted = 1'b0;
        end
      end
    end while (!sorted);
    dn = (r == y_lo);
    nsp = edge_n / 2;
    if (nsp > SPAN_CAP) nsp = SPAN_CAP;
    if (dn) phase = psf_pkg::PH_DONE;
    else row_now = row_now - 13'd1;
    if (nsp == 0) begin
      res.push_back(beat(r[11:0], '0, '0, 1'b0, 1'b1, dn, 1'b0));
      return;
    end
    for (int k = 0; k < nsp; k++)
      res.push_back(beat(r[11:0], edge_end(edge_pos[2 * k], edge_step[2 * k]),
                         edge_end(edge_pos[2 * k + 1], edge_step[2 * k + 1]),
                         1'b1, k + 1 == nsp, dn, 1'b0));
  endfunction

  function automatic void fill_step(logic [1:0] k, logic [11:0] vx, logic [11:0] vy,
                                    ref span_beat_t res[$]);
    case (k)
      psf_pkg::KIND_LOAD: begin
        if (phase != psf_pkg::PH_LOADING) begin
          res.push_back(beat('0, '0, '0, 1'b0, 1'b1, 1'b0, 1'b0));
        end else if (vert_n >= VERTS) begin
          res.push_back(beat('0, '0, '0, 1'b0, 1'b1, 1'b0, 1'b1));
        end else begin
          vx_mem[vert_n] = vx;
          vy_mem[vert_n] = vy;
          vert_n++;
          if (vy < y_lo) y_lo = vy;
          if (vy > y_hi) y_hi = vy;
          res.push_back(beat('0, '0, '0, 1'b0, 1'b1, 1'b0, 1'b0));
        end
      end
      psf_pkg::KIND_ROW: begin
        if (phase == psf_pkg::PH_DONE) begin
          res.push_back(beat('0, '0, '0, 1'b0, 1'b1, 1'b1, 1'b0));
        end else if (phase == psf_pkg::PH_LOADING && (vert_n < 3 || y_hi <= y_lo)) begin
          phase = psf_pkg::PH_DONE;
          res.push_back(beat('0, '0, '0, 1'b0, 1'b1, 1'b1, 1'b0));
        end else begin
          if (phase == psf_pkg::PH_LOADING) begin
            foreach (seg_in[i]) seg_in[i] = 1'b0;
            edge_n = 0;
            row_now = {1'b0, y_hi} - 13'd1;
            phase = psf_pkg::PH_FILLING;
          end
          next_row(res);
        end
      end
      default: begin
        if (k == psf_pkg::KIND_CLEAR) clear_fill();
        res.push_back(beat('0, '0, '0, 1'b0, 1'b1, 1'b0, 1'b0));
      end
    endcase
  endfunction

  task automatic send_beat(logic [1:0] k, logic [11:0] vx, logic [11:0] vy,
                           bit typed = 1'b0, span_beat_t want = '0);
    span_beat_t res[$];
    int gap_pct;
    gap_pct = (idle_mode == 1) ? 68 : (idle_mode == 3) ? 30 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_vertex_x <= vx;
    in_vertex_y <= vy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fill_step(k, vx, vy, res);
    if (typed) spans_pending.push_back(want);
    else foreach (res[i]) spans_pending.push_back(res[i]);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (spans_pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic run_polygon(int n, int h, bit long_hold);
    logic [11:0] base, x0, y0, vx, vy;
    int guard;
    base = ($urandom_range(3) == 0) ? 12'(4095 - h) : 12'($urandom_range(4095 - h));
    send_beat(psf_pkg::KIND_CLEAR, 12'($urandom), 12'($urandom));
    for (int i = 0; i < n; i++) begin
      vx = ($urandom_range(1) == 0) ? 12'($urandom) : 12'($urandom_range(80) + 1000);
      vy = base + 12'($urandom_range(h));
      if (i == 0) begin
        x0 = vx;
        y0 = vy;
      end
      send_beat(psf_pkg::KIND_LOAD, vx, vy);
    end
    send_beat(psf_pkg::KIND_LOAD, x0, y0);
    if (long_hold) hold_req++;
    guard = 0;
    while (phase != psf_pkg::PH_DONE && guard < 64) begin
      send_beat(psf_pkg::KIND_ROW, 12'($urandom), 12'($urandom));
      guard++;
    end
    send_beat(psf_pkg::KIND_ROW, 12'($urandom), 12'($urandom));
    if ($urandom_range(2) == 0)
      send_beat(psf_pkg::KIND_LOAD, 12'($urandom), 12'($urandom));
  endtask

  task automatic report_mismatch(string what, logic [11:0] got, logic [11:0] want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // receiver side: random stall plus one long hold-off
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (idle_mode == 2) begin
      out_stall <= ($urandom_range(99) < 68);
    end else if (idle_mode == 3) begin
      out_stall <= ($urandom_range(99) < 30);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    span_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (spans_pending.size() == 0) begin
        report_mismatch("unexpected beat row", out_span_row, '0);
      end else begin
        want = spans_pending.pop_front();
        if (out_span_row !== want.row) report_mismatch("row", out_span_row, want.row);
        if (out_span_left !== want.left) report_mismatch("left", out_span_left, want.left);
        if (out_span_right !== want.right)
          report_mismatch("right", out_span_right, want.right);
        if (out_span_valid !== want.span_valid)
          report_mismatch("span_valid", out_span_valid, want.span_valid);
        if (out_last !== want.last) report_mismatch("last", out_last, want.last);
        if (out_done_res !== want.done) report_mismatch("done", out_done_res, want.done);
        if (out_overflow !== want.overflow)
          report_mismatch("overflow", out_overflow, want.overflow);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  stim_row_t directed [$];
  span_beat_t ack, done_ack;
  int seq;

  initial begin
    clear_fill();
    ack = beat('0, '0, '0, 1'b0, 1'b1, 1'b0, 1'b0);
    done_ack = beat('0, '0, '0, 1'b0, 1'b1, 1'b1, 1'b0);
    directed = '{
      '{psf_pkg::KIND_ROW,   12'd0,    12'd0,    1'b1, done_ack},
      '{psf_pkg::KIND_ROW,   12'd0,    12'd0,    1'b1, done_ack},
      '{psf_pkg::KIND_LOAD,  12'd4095, 12'd4095, 1'b1, ack},
      '{KIND_SPARE,          12'd4095, 12'd4095, 1'b1, ack},
      '{psf_pkg::KIND_CLEAR, 12'd0,    12'd0,    1'b1, ack},
      '{psf_pkg::KIND_LOAD,  12'd0,    12'd1,    1'b1, ack},
      '{psf_pkg::KIND_LOAD,  12'd4095, 12'd3,    1'b1, ack},
      '{psf_pkg::KIND_LOAD,  12'd10,   12'd3,    1'b1, ack},
      '{psf_pkg::KIND_LOAD,  12'd0,    12'd1,    1'b1, ack},
      '{psf_pkg::KIND_ROW,   12'd0,    12'd0,    1'b0, ack},
      '{psf_pkg::KIND_LOAD,  12'd7,    12'd7,    1'b1, ack},
      '{psf_pkg::KIND_ROW,   12'd0,    12'd0,    1'b0, ack},
      '{psf_pkg::KIND_ROW,   12'd0,    12'd0,    1'b1, done_ack},
      '{psf_pkg::KIND_CLEAR, 12'd0,    12'd0,    1'b1, ack},
      '{psf_pkg::KIND_LOAD,  12'd4095, 12'd0,    1'b1, ack},
      '{psf_pkg::KIND_LOAD,  12'd0,    12'd4095, 1'b1, ack},
      '{psf_pkg::KIND_ROW,   12'd0,    12'd0,    1'b1, done_ack},
      '{psf_pkg::KIND_CLEAR, 12'd0,    12'd0,    1'b1, ack},
      '{psf_pkg::KIND_LOAD,  12'd0,    12'd4095, 1'b1, ack},
      '{psf_pkg::KIND_LOAD,  12'd4095, 12'd4093, 1'b1, ack},
      '{psf_pkg::KIND_LOAD,  12'd0,    12'd4093, 1'b1, ack},
      '{psf_pkg::KIND_LOAD,  12'd0,    12'd4095, 1'b1, ack},
      '{psf_pkg::KIND_ROW,   12'd0,    12'd0,    1'b0, ack},
      '{psf_pkg::KIND_ROW,   12'd0,    12'd0,    1'b0, ack}
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i])
      send_beat(directed[i].kind, directed[i].vx, directed[i].vy,
                directed[i].typed, directed[i].want);
    drain();

    // store full: 66 loads into a short polygon, then walk its rows
    idle_mode = 3;
    run_polygon(65, 3, 1'b0);
    drain();

    seq = 0;
    while (items_sent < RAND_ITEMS) begin
      idle_mode = (seq / 3) % 4;
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(6, 2))
          send_beat(2'($urandom), 12'($urandom), 12'($urandom));
      end else begin
        run_polygon($urandom_range(8, 2), $urandom_range(12, 1), seq == 4);
      end
      if (seq % 5 == 4) drain();
      seq++;
    end
    drain();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
